/* hw/rtl/hrhp_pkg.sv */
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the HTTP request header parser
// Event codes, the result record passed from the front to the back, queue
// sizing and the Content-Length prefix table.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

  // Result event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_REQ_LINE = 3'd1;
  localparam logic [2:0] EV_HDR_LINE = 3'd2;
  localparam logic [2:0] EV_BODY     = 3'd3;
  localparam logic [2:0] EV_DONE     = 3'd4;
  localparam logic [2:0] EV_NO_REQ   = 3'd5;

  // Character codes
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // Prefix length of "CONTENT-LENGTH:"
  localparam logic [3:0] PREFIX_LEN = 4'd15;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One classified byte: a first result, optionally followed by content done
  typedef struct packed {
    logic       two;      // a content done result follows
    logic [2:0] ev;
    logic [7:0] data;
    logic [7:0] len;
    logic [15:0] blen;
    logic       fe;
  } hrhp_rec_t;

  // Upper-case prefix character at a match position
  function automatic logic [7:0] prefix_char(input logic [3:0] pos);
    logic [7:0] c;
    unique case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h4F; // O
      4'd2:    c = 8'h4E; // N
      4'd3:    c = 8'h54; // T
      4'd4:    c = 8'h45; // E
      4'd5:    c = 8'h4E; // N
      4'd6:    c = 8'h54; // T
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h45; // E
      4'd10:   c = 8'h4E; // N
      4'd11:   c = 8'h47; // G
      4'd12:   c = 8'h54; // T
      4'd13:   c = 8'h48; // H
      4'd14:   c = 8'h3A; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/hrhp_front.sv */
// ----------------------------------------------------------------------------
// hrhp_front: byte classifier and parser state
// Holds the line, prefix match, number and body state, updates it once per
// accepted byte and pushes one record for every byte that gives results.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_front
  import hrhp_pkg::*;
#(
  parameter int LINE_MAX = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        acc,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_end,
  output logic             push,
  output hrhp_rec_t        rec
);

  // Phase codes
  localparam logic [2:0] PH_REQ       = 3'd0;
  localparam logic [2:0] PH_HDR       = 3'd1;
  localparam logic [2:0] PH_SKIP_HDR  = 3'd2;
  localparam logic [2:0] PH_SKIP_BODY = 3'd3;
  localparam logic [2:0] PH_BODY      = 3'd4;
  localparam logic [2:0] PH_SKIP_REQ  = 3'd5;

  // Number parser codes
  localparam logic [1:0] DP_PREFIX = 2'd0;
  localparam logic [1:0] DP_WHITE  = 2'd1;
  localparam logic [1:0] DP_DIGITS = 2'd2;
  localparam logic [1:0] DP_DONE   = 2'd3;

  localparam logic [7:0] LINE_LIM = 8'(LINE_MAX);

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  line_r, line_nxt;
  logic [3:0]  mpos_r, mpos_nxt;
  logic        mok_r, mok_nxt;
  logic [1:0]  dp_r, dp_nxt;
  logic [15:0] decl_r, decl_nxt;
  logic [15:0] pval_r, pval_nxt;
  logic [15:0] bcnt_r, bcnt_nxt;

  logic [2:0]  ph;
  logic        swallow;
  logic        is_cr;
  logic        is_digit;
  logic        is_white;
  logic [7:0]  up;
  logic [3:0]  dval;
  logic [19:0] mul10;
  logic [15:0] bcnt_inc;
  logic [15:0] new_decl;

  // Byte classes
  always_comb begin
    is_cr    = (data_byte == CH_CR);
    is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    is_white = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
    up       = ((data_byte >= 8'h61) && (data_byte <= 8'h7A)) ? (data_byte - 8'h20)
                                                              : data_byte;
    dval     = 4'(data_byte - 8'h30);
    mul10    = ({4'b0, pval_r} << 3) + ({4'b0, pval_r} << 1) + {16'b0, dval};
    bcnt_inc = bcnt_r + 16'd1;
    new_decl = (dp_r != DP_PREFIX) ? pval_r : decl_r;
  end

  // Per-byte parser step
  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    mpos_nxt  = mpos_r;
    mok_nxt   = mok_r;
    dp_nxt    = dp_r;
    decl_nxt  = decl_r;
    pval_nxt  = pval_r;
    bcnt_nxt  = bcnt_r;
    push      = 1'b0;
    swallow   = 1'b0;
    rec.two   = 1'b0;
    rec.ev    = EV_NONE;
    rec.data  = 8'h00;
    rec.len   = 8'h00;
    rec.blen  = decl_r;
    rec.fe    = frame_end;
    ph        = (phase_r > PH_SKIP_REQ) ? PH_REQ : phase_r;

    if (acc) begin
      // leave a skip phase; an LF there is only the tail of CR LF
      if (ph == PH_SKIP_HDR || ph == PH_SKIP_BODY || ph == PH_SKIP_REQ) begin
        ph      = (ph == PH_SKIP_HDR) ? PH_HDR : (ph == PH_SKIP_BODY) ? PH_BODY : PH_REQ;
        swallow = (data_byte == CH_LF);
      end
      phase_nxt = ph;

      if (!swallow) begin
        if (ph == PH_BODY) begin
          // body byte, content done at the declared length
          push     = 1'b1;
          rec.ev   = EV_BODY;
          rec.data = data_byte;
          bcnt_nxt = bcnt_inc;
          if (bcnt_inc >= decl_r) begin
            rec.two   = 1'b1;
            phase_nxt = PH_REQ;
            decl_nxt  = 16'd0;
            bcnt_nxt  = 16'd0;
            line_nxt  = 8'd0;
            mpos_nxt  = 4'd0;
            mok_nxt   = 1'b1;
            dp_nxt    = DP_PREFIX;
            pval_nxt  = 16'd0;
          end
        end else if (data_byte != CH_CR && data_byte != CH_LF) begin
          // stored line byte; header bytes feed the prefix match and number
          if (line_r < LINE_LIM) begin
            line_nxt = line_r + 8'd1;
            if (ph == PH_HDR) begin
              unique case (dp_r)
                DP_PREFIX: begin
                  if (mok_r && mpos_r < PREFIX_LEN) begin
                    if (up == prefix_char(mpos_r)) begin
                      mpos_nxt = mpos_r + 4'd1;
                      if (mpos_r + 4'd1 == PREFIX_LEN) begin
                        dp_nxt = DP_WHITE;
                      end
                    end else begin
                      mok_nxt = 1'b0;
                    end
                  end
                end
                DP_WHITE: begin
                  if (is_white) begin
                    dp_nxt = DP_WHITE;
                  end else if (data_byte == 8'h2B) begin
                    dp_nxt = DP_DIGITS;
                  end else if (is_digit) begin
                    pval_nxt = {12'b0, dval};
                    dp_nxt   = DP_DIGITS;
                  end else begin
                    pval_nxt = 16'd0;
                    dp_nxt   = DP_DONE;
                  end
                end
                DP_DIGITS: begin
                  if (is_digit) begin
                    pval_nxt = (mul10 > 20'd65535) ? 16'hFFFF : mul10[15:0];
                  end else begin
                    dp_nxt = DP_DONE;
                  end
                end
                default: begin
                  dp_nxt = dp_r;
                end
              endcase
            end
          end
        end else begin
          // line end
          push     = 1'b1;
          line_nxt = 8'd0;
          mpos_nxt = 4'd0;
          mok_nxt  = 1'b1;
          dp_nxt   = DP_PREFIX;
          pval_nxt = 16'd0;
          if (line_r == 8'd0) begin
            if (ph == PH_REQ) begin
              rec.ev = EV_NO_REQ;
            end else begin
              rec.ev = EV_HDR_LINE;
              if (decl_r == 16'd0) begin
                rec.two   = 1'b1;
                decl_nxt  = 16'd0;
                bcnt_nxt  = 16'd0;
                phase_nxt = is_cr ? PH_SKIP_REQ : PH_REQ;
              end else begin
                bcnt_nxt  = 16'd0;
                phase_nxt = is_cr ? PH_SKIP_BODY : PH_BODY;
              end
            end
          end else if (ph == PH_REQ) begin
            rec.ev    = EV_REQ_LINE;
            rec.len   = line_r;
            phase_nxt = is_cr ? PH_SKIP_HDR : PH_HDR;
          end else begin
            rec.ev    = EV_HDR_LINE;
            rec.len   = line_r;
            rec.blen  = new_decl;
            decl_nxt  = new_decl;
            phase_nxt = is_cr ? PH_SKIP_HDR : PH_HDR;
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_REQ;
      line_r  <= 8'd0;
      mpos_r  <= 4'd0;
      mok_r   <= 1'b1;
      dp_r    <= DP_PREFIX;
      decl_r  <= 16'd0;
      pval_r  <= 16'd0;
      bcnt_r  <= 16'd0;
    end else begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      mpos_r  <= mpos_nxt;
      mok_r   <= mok_nxt;
      dp_r    <= dp_nxt;
      decl_r  <= decl_nxt;
      pval_r  <= pval_nxt;
      bcnt_r  <= bcnt_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hrhp_queue.sv */
// ----------------------------------------------------------------------------
// hrhp_queue: record queue between front and back
// Small first-in first-out buffer in flops; full stalls the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_queue
  import hrhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire hrhp_rec_t wr_rec,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output hrhp_rec_t      rd_rec
);

  hrhp_rec_t      mem [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == (QAW+1)'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_rec    = mem[rp_r];

  // Pointer and fill count update
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(push) - (QAW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hrhp_back.sv */
// ----------------------------------------------------------------------------
// hrhp_back: result sequencer and output register
// Pops records and emits one result transaction per cycle while out_stall is low,
// adding the content done result after a record that carries one.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_back
  import hrhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_avail,
  input  wire hrhp_rec_t   q_rec,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_byte,
  output logic [7:0]       out_line_length,
  output logic [15:0]      out_body_length,
  output logic             out_frame_end_seen,
  output logic             out_last
);

  logic        vld_r;
  logic        pend_r;
  logic [2:0]  ev_r;
  logic [7:0]  data_r;
  logic [7:0]  len_r;
  logic [15:0] blen_r;
  logic        fe_r;
  logic        last_r;
  logic        slot_free;

  // Output slot frees when empty or taken this cycle
  assign slot_free = !vld_r || !out_stall;
  assign pop       = slot_free && !pend_r && q_avail;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      pend_r <= 1'b0;
    end else if (slot_free) begin
      if (pend_r) begin
        vld_r  <= 1'b1;
        pend_r <= 1'b0;
      end else begin
        vld_r  <= q_avail;
        pend_r <= q_avail && q_rec.two;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (pend_r) begin
        ev_r   <= EV_DONE;
        data_r <= 8'h00;
        len_r  <= 8'h00;
        last_r <= 1'b1;
      end else if (q_avail) begin
        ev_r   <= q_rec.ev;
        data_r <= q_rec.data;
        len_r  <= q_rec.len;
        blen_r <= q_rec.blen;
        fe_r   <= q_rec.fe;
        last_r <= !q_rec.two;
      end
    end
  end

  assign out_valid          = vld_r;
  assign out_event_res      = ev_r;
  assign out_byte           = data_r;
  assign out_line_length    = len_r;
  assign out_body_length    = blen_r;
  assign out_frame_end_seen = fe_r;
  assign out_last           = last_r;

endmodule

`default_nettype wire

/* hw/rtl/http_request_header_parser.sv */
// ----------------------------------------------------------------------------
// http_request_header_parser: byte-wise HTTP request line and header parser
// Splits a request stream into lines, tracks Content-Length and passes out
// body bytes with a content done marker.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while the four-entry record queue between
// the parser front and the result back has room. Each byte is parsed in the
// cycle it is accepted and its record enters the queue; the back registers
// the result at out_* when the output is free and sends one result per
// cycle while out_stall is low, so the sustained rate is one byte per cycle
// except for bytes that give two results (the byte completing a body, or a
// blank header line with zero declared length); the queue absorbs these
// and short output stalls. Bytes that give no result (stored line bytes,
// the LF of CR LF) only update the parser state.
`default_nettype none

module http_request_header_parser
  import hrhp_pkg::*;
#(
  parameter int LINE_MAX = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_frame_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_event_res,
  output logic [7:0]       out_byte,
  output logic [7:0]       out_line_length,
  output logic [15:0]      out_body_length,
  output logic             out_frame_end_seen,
  output logic             out_last
);

  logic      q_full;
  logic      acc;
  logic      push;
  hrhp_rec_t rec;
  logic      q_avail;
  hrhp_rec_t q_rec;
  logic      pop;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  // Parser front
  hrhp_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_data_byte),
    .frame_end (in_frame_end),
    .push      (push),
    .rec       (rec)
  );

  // Record queue
  hrhp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_rec    (rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_avail),
    .rd_rec    (q_rec)
  );

  // Result back
  hrhp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_avail            (q_avail),
    .q_rec              (q_rec),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_byte           (out_byte),
    .out_line_length    (out_line_length),
    .out_body_length    (out_body_length),
    .out_frame_end_seen (out_frame_end_seen),
    .out_last           (out_last)
  );

  // A non-last result is always followed at once by content done
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last)
      |=> (out_valid && out_event_res == EV_DONE && out_last))
    else $error("content done does not follow a non-last result");

  // Content done always closes its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res == EV_DONE) |-> out_last)
    else $error("content done not marked last");

  // Only body bytes carry data
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_BODY) |-> (out_byte == 8'h00))
    else $error("data on a non-body result");

  // Only line ends carry a length
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_res != EV_REQ_LINE && out_event_res != EV_HDR_LINE)
      |-> (out_line_length == 8'h00))
    else $error("line length on a non-line result");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for http_request_header_parser
// Feeds request streams byte by byte (request lines, plain and Content-Length
// headers, blank lines, bodies, line noise) with random idle on both sides and
// compares every result transaction against a cycle-free parser model.
// ----------------------------------------------------------------------------

module tb;
  import hrhp_pkg::*;

  localparam int LINE_MAX     = 128;
  localparam int RANDOM_BYTES = 1450;
  localparam int HOLD_CYCLES  = 250;   // long output hold-off to fill the queue
  localparam int STALL_LIMIT  = 2000;  // quiet cycles before the run is abandoned
  localparam int DRAIN_CYCLES = 64;

  localparam logic [8*15-1:0] LENGTH_PREFIX = "CONTENT-LENGTH:";

  // One result transaction
  typedef struct packed {
    logic [2:0]  ev;
    logic [7:0]  data;
    logic [7:0]  len;
    logic [15:0] blen;
    logic        fe;
    logic        last;
  } parse_result_t;

  // --------------------------------------------------------------------------
  // Parser model and expected-result store
  // --------------------------------------------------------------------------
  class parse_scoreboard;
    localparam logic [2:0] PH_REQ       = 3'd0;
    localparam logic [2:0] PH_HDR       = 3'd1;
    localparam logic [2:0] PH_SKIP_HDR  = 3'd2;
    localparam logic [2:0] PH_SKIP_BODY = 3'd3;
    localparam logic [2:0] PH_BODY      = 3'd4;
    localparam logic [2:0] PH_SKIP_REQ  = 3'd5;

    localparam logic [1:0] DG_PREFIX = 2'd0;
    localparam logic [1:0] DG_SPACE  = 2'd1;
    localparam logic [1:0] DG_DIGITS = 2'd2;
    localparam logic [1:0] DG_DONE   = 2'd3;

    parse_result_t pending[$];
    int            errors;

    logic [2:0]  phase;
    logic [7:0]  line_count;
    logic [3:0]  match_pos;
    logic        match_ok;
    logic [1:0]  digit_phase;
    logic [15:0] declared_length;
    logic [15:0] parsed_value;
    logic [15:0] body_count;

    function new();
      errors          = 0;
      phase           = PH_REQ;
      declared_length = '0;
      body_count      = '0;
      clear_line();
    endfunction

    function void clear_line();
      line_count   = '0;
      match_pos    = '0;
      match_ok     = 1'b1;
      digit_phase  = DG_PREFIX;
      parsed_value = '0;
    endfunction

    function bit in_body();
      return phase == PH_BODY || phase == PH_SKIP_BODY;
    endfunction

    function parse_result_t result_of(logic [2:0] ev, logic [7:0] data, logic [7:0] len,
                                      logic fe);
      parse_result_t r;
      r.ev   = ev;
      r.data = data;
      r.len  = len;
      r.blen = declared_length;
      r.fe   = fe;
      r.last = 1'b0;
      return r;
    endfunction

    // Prefix match and Content-Length number parsing of one stored header byte
    function void header_char(logic [7:0] b);
      logic [7:0]  up;
      int unsigned v;
      up = (b >= "a" && b <= "z") ? b - 8'h20 : b;
      case (digit_phase)
        DG_PREFIX: begin
          if (match_ok && match_pos < PREFIX_LEN) begin
            if (up == LENGTH_PREFIX[8*(14 - match_pos) +: 8]) begin
              match_pos++;
              if (match_pos == PREFIX_LEN) digit_phase = DG_SPACE;
            end else begin
              match_ok = 1'b0;
            end
          end
        end
        DG_SPACE: begin
          if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
            // leading white space is skipped
          end else if (b == "+") begin
            digit_phase = DG_DIGITS;
          end else if (b >= "0" && b <= "9") begin
            parsed_value = 16'(b - "0");
            digit_phase  = DG_DIGITS;
          end else begin
            parsed_value = '0;
            digit_phase  = DG_DONE;
          end
        end
        DG_DIGITS: begin
          if (b >= "0" && b <= "9") begin
            v = int'(parsed_value) * 10 + int'(b - "0");
            parsed_value = (v > 65535) ? 16'hFFFF : 16'(v);
          end else begin
            digit_phase = DG_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    // Accepted input byte: advance the model and queue what it produces
    function void note_byte(logic [7:0] b, logic fe);
      parse_result_t r[2];
      int            n;
      bit            cr;
      logic [7:0]    len;
      n = 0;
      if (phase > PH_SKIP_REQ) phase = PH_REQ;

      // LF of a CR LF pair is swallowed
      if (phase == PH_SKIP_HDR || phase == PH_SKIP_BODY || phase == PH_SKIP_REQ) begin
        phase = (phase == PH_SKIP_HDR) ? PH_HDR : (phase == PH_SKIP_BODY) ? PH_BODY : PH_REQ;
        if (b == CH_LF) return;
      end

      if (phase == PH_BODY) begin
        r[n] = result_of(EV_BODY, b, 8'd0, fe);
        n++;
        body_count++;
        if (body_count >= declared_length) begin
          r[n] = result_of(EV_DONE, 8'd0, 8'd0, fe);
          n++;
          phase           = PH_REQ;
          declared_length = '0;
          body_count      = '0;
          clear_line();
        end
      end else if (b != CH_CR && b != CH_LF) begin
        // bytes beyond the line limit are dropped
        if (line_count < LINE_MAX) begin
          if (phase == PH_HDR) header_char(b);
          line_count++;
        end
      end else begin
        cr  = (b == CH_CR);
        len = line_count;
        if (len == 0) begin
          if (phase == PH_REQ) begin
            r[n] = result_of(EV_NO_REQ, 8'd0, 8'd0, fe);
            n++;
          end else begin
            r[n] = result_of(EV_HDR_LINE, 8'd0, 8'd0, fe);
            n++;
            if (declared_length == 0) begin
              r[n] = result_of(EV_DONE, 8'd0, 8'd0, fe);
              n++;
              body_count = '0;
              phase      = cr ? PH_SKIP_REQ : PH_REQ;
            end else begin
              body_count = '0;
              phase      = cr ? PH_SKIP_BODY : PH_BODY;
            end
          end
        end else if (phase == PH_REQ) begin
          r[n] = result_of(EV_REQ_LINE, 8'd0, len, fe);
          n++;
          phase = cr ? PH_SKIP_HDR : PH_HDR;
        end else begin
          if (digit_phase != DG_PREFIX) declared_length = parsed_value;
          r[n] = result_of(EV_HDR_LINE, 8'd0, len, fe);
          n++;
          phase = cr ? PH_SKIP_HDR : PH_HDR;
        end
        clear_line();
      end

      if (n > 0) r[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) pending.push_back(r[i]);
    endfunction

    // Accepted result transaction against the oldest expectation
    function void check_result(parse_result_t got);
      parse_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: ev=%0d byte=%02h len=%0d blen=%0d fe=%0b last=%0b",
                   got.ev, got.data, got.len, got.blen, got.fe, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.ev !== want.ev || got.data !== want.data || got.len !== want.len ||
          got.blen !== want.blen || got.fe !== want.fe || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected ev=%0d byte=%02h len=%0d blen=%0d fe=%0b last=%0b",
                   want.ev, want.data, want.len, want.blen, want.fe, want.last);
          $display("          got      ev=%0d byte=%02h len=%0d blen=%0d fe=%0b last=%0b",
                   got.ev, got.data, got.len, got.blen, got.fe, got.last);
        end
      end
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        errors++;
        $display("%0d expected results never arrived", pending.size());
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT and shared state
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_event_res;
  logic [7:0]  out_byte;
  logic [7:0]  out_line_length;
  logic [15:0] out_body_length;
  logic        out_frame_end_seen;
  logic        out_last;

  parse_scoreboard sb = new();

  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  bit hold_due   = 1'b0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  http_request_header_parser #(
    .LINE_MAX(LINE_MAX)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_byte          (out_byte),
    .out_line_length   (out_line_length),
    .out_body_length   (out_body_length),
    .out_frame_end_seen(out_frame_end_seen),
    .out_last          (out_last)
  );

  // --------------------------------------------------------------------------
  // Byte stream drivers
  // --------------------------------------------------------------------------

  // One input transaction with a random lead-in gap
  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic fe;
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    fe  = ($urandom_range(0, 7) == 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_byte(b, fe);
    bytes_sent++;
    if (bytes_sent == 400 || bytes_sent == 1000) hold_due = 1'b1;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Any byte that does not end a line
  function automatic logic [7:0] line_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] white_char();
    case ($urandom_range(0, 3))
      0:       return 8'h20;
      1:       return 8'h09;
      2:       return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  task automatic end_line();
    case ($urandom_range(0, 2))
      0: send_byte(CH_CR);
      1: send_byte(CH_LF);
      default: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
    endcase
  endtask

  task automatic send_junk(input int n);
    repeat (n) send_byte(line_char());
  endtask

  // Content-Length header body: mixed case, optional white space and sign
  task automatic send_length_header(input string num, input bit may_break);
    logic [7:0] c;
    int         bad_pos;
    bad_pos = (may_break && $urandom_range(0, 5) == 0) ? $urandom_range(0, 14) : -1;
    for (int i = 0; i < 15; i++) begin
      c = LENGTH_PREFIX[8*(14 - i) +: 8];
      if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) c = c + 8'h20;
      if (i == bad_pos) c = c ^ 8'h01;
      send_byte(c);
    end
    repeat ($urandom_range(0, 2)) send_byte(white_char());
    case ($urandom_range(0, 7))
      0:       send_byte("+");
      1:       send_byte("-");
      default: ;
    endcase
    send_string(num);
    if ($urandom_range(0, 3) == 0) send_byte(line_char());
  endtask

  // Digits run past the line limit: only the first two get stored
  task automatic send_clipped_length();
    send_string("Content-Length:");
    repeat (111) send_byte(8'h20);
    send_string("1234567");
  endtask

  function automatic string small_number();
    if ($urandom_range(0, 3) == 0) return $sformatf("%03d", $urandom_range(0, 15));
    return $sformatf("%0d", $urandom_range(0, 15));
  endfunction

  // Request line, headers, blank line and the body it declares
  task automatic send_request();
    bit big_seen;
    big_seen = 1'b0;
    if ($urandom_range(0, 19) == 0) send_junk(LINE_MAX + $urandom_range(1, 12));
    else send_junk($urandom_range(1, 12));
    end_line();

    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: begin
          big_seen = 1'b1;
          case ($urandom_range(0, 4))
            0:       send_length_header("65535", 1'b1);
            1:       send_length_header("65536", 1'b1);
            2:       send_length_header("99999", 1'b1);
            3:       send_length_header("4294967296", 1'b1);
            default: send_length_header("000070000", 1'b1);
          endcase
        end
        1: send_length_header($sformatf("%0d", $urandom_range(16, 40)), 1'b1);
        2: send_length_header(($urandom_range(0, 1) == 1) ? "" : small_number(), 1'b1);
        default: send_junk($urandom_range(1, 20));
      endcase
      end_line();
    end

    // last length header keeps the body short
    if (big_seen || $urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 9) == 0) send_clipped_length();
      else send_length_header(small_number(), 1'b0);
      end_line();
    end

    end_line();
    while (sb.in_body()) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Line noise with plenty of line ends
  task automatic send_noise();
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 2) == 0) send_byte(($urandom_range(0, 1) == 1) ? CH_CR : CH_LF);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink with random stalls and two long hold-offs in the run
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int            gap;
    parse_result_t got;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 15);
      if (hold_due) begin
        gap      = HOLD_CYCLES;
        hold_due = 1'b0;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.ev   = out_event_res;
      got.data = out_byte;
      got.len  = out_line_length;
      got.blen = out_body_length;
      got.fe   = out_frame_end_seen;
      got.last = out_last;
      sb.check_result(got);
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: abandon the run when no transaction moves for too long
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int first_random;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // blank request line ended by CR LF: two missing request line events
    send_byte(CH_CR);
    send_byte(CH_LF);
    // request line of extreme bytes, LF swallowed
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(CH_LF);
    // blank header with no length: header end plus content done
    send_byte(CH_CR);
    send_byte(CH_LF);
    // two-byte body made of line end characters
    send_byte("R");
    send_byte(CH_LF);
    send_string("content-Length:2");
    send_byte(CH_LF);
    send_byte(CH_LF);
    send_byte(CH_CR);
    send_byte(CH_LF);

    // random requests mixed with noise
    first_random = bytes_sent;
    while (bytes_sent - first_random < RANDOM_BYTES) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      else send_request();
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then allow for stray results
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
